[rtl/core/asf_pkg.sv]
// Shared types and constants for the anisotropic scale factor pipeline.
// Used by asf_exp_step and anisotropic_scale_factor; no dependencies.
`default_nettype none

package asf_pkg;

  // Fixed field widths
  localparam int unsigned COEF_BITS    = 40;
  localparam int unsigned EXP_BITS     = 8;
  localparam int unsigned CFG_IDX_BITS = 3;

  // Exponential datapath: series terms carry 62 fraction bits, the sum 63 bits
  localparam int unsigned TERM_BITS = 62;
  localparam int unsigned ACC_BITS  = TERM_BITS + 1;

  // Argument x = -Q with 34 fraction bits, range [-2^41, 160 * 2^32]
  localparam int unsigned X_BITS   = 43;
  // x splits into a signed upper part and an unsigned 22-bit lower part
  localparam int unsigned XLO_BITS = 22;
  localparam int unsigned XHI_BITS = X_BITS - XLO_BITS;
  // One part of x times one 32-bit half of log2(e)
  localparam int unsigned XP_BITS  = XLO_BITS + 34;
  // Full product x * log2(e): integer part above bit 96, fraction in [96:33]
  localparam int unsigned Y_BITS   = X_BITS + 65;
  localparam int unsigned N_BITS   = Y_BITS - 97;

  // Terms past the seventeenth are zero for any z below ln 2, and the first
  // term equals z, so the series runs for terms two through seventeen.
  localparam int unsigned NUM_STEPS = 16;

  localparam logic [63:0] LOG2E_Q63 = 64'hB8AA_3B29_5C17_F0BC;
  localparam logic [63:0] LN2_Q64   = 64'hB172_17F7_D1CF_79AB;

  // Argument limit 40 with 34 fraction bits
  localparam logic signed [X_BITS-1:0] X_CLAMP = 43'h0A0_0000_0000;
  // Constant term of the series: 1.0 with 62 fraction bits
  localparam logic [ACC_BITS-1:0] ACC_ONE = 63'h4000_0000_0000_0000;

  typedef logic [TERM_BITS-1:0] term_t;
  typedef logic [ACC_BITS-1:0]  acc_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_HH = 3'd0,
    CFG_KK = 3'd1,
    CFG_LL = 3'd2,
    CFG_HK = 3'd3,
    CFG_HL = 3'd4,
    CFG_KL = 3'd5
  } cfg_idx_t;

  // Per-item control that travels alongside the series datapath
  typedef struct packed {
    logic                       vld;
    logic                       clamped;
    logic                       underflow;
    logic signed [EXP_BITS-1:0] exponent;
  } asf_side_t;

endpackage

`default_nettype wire

[rtl/core/asf_exp_step.sv]
// One term of the exponential series: term * z, scaled, divided by DIVISOR.
// Five register stages; depends on asf_pkg.
`default_nettype none

module asf_exp_step #(
  parameter int unsigned DIVISOR = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  asf_pkg::asf_side_t  side_in,
  input  asf_pkg::term_t      z_in,
  input  asf_pkg::term_t      term_in,
  input  asf_pkg::acc_t       sum_in,
  output asf_pkg::asf_side_t  side_out,
  output asf_pkg::term_t      z_out,
  output asf_pkg::term_t      term_out,
  output asf_pkg::acc_t       sum_out
);
  import asf_pkg::*;

  // Reciprocal floor((2^64 - 1) / k) is at most one below 2^64 / k, so the
  // estimated quotient is exact or one short
  localparam logic [63:0] RECIP    = 64'hFFFF_FFFF_FFFF_FFFF / 64'(DIVISOR);
  localparam logic [31:0] RECIP_HI = RECIP[63:32];
  localparam logic [31:0] RECIP_LO = RECIP[31:0];
  localparam logic [7:0]  DIV_LO   = 8'(DIVISOR);

  // Stage 1: partial products of term * z, accumulate incoming term
  asf_side_t   side1_r;
  term_t       z1_r;
  acc_t        sum1_r;
  logic [63:0] pa_hh_r, pa_hl_r, pa_lh_r, pa_ll_r;
  logic [63:0] pa_hh_nxt, pa_hl_nxt, pa_lh_nxt, pa_ll_nxt;
  acc_t        sum1_nxt;

  assign pa_hh_nxt = 64'(term_in[61:32]) * 64'(z_in[61:32]);
  assign pa_hl_nxt = 64'(term_in[61:32]) * 64'(z_in[31:0]);
  assign pa_lh_nxt = 64'(term_in[31:0]) * 64'(z_in[61:32]);
  assign pa_ll_nxt = 64'(term_in[31:0]) * 64'(z_in[31:0]);
  assign sum1_nxt  = sum_in + ACC_BITS'(term_in);

  // Stage 2: v = floor(term * z / 2^62)
  asf_side_t    side2_r;
  term_t        z2_r;
  acc_t         sum2_r;
  term_t        v2_r;
  logic [127:0] prod_a;

  assign prod_a = (128'(pa_hh_r) << 64) + ((128'(pa_hl_r) + 128'(pa_lh_r)) << 32)
                + 128'(pa_ll_r);

  // Stage 3: partial products of v * reciprocal
  asf_side_t   side3_r;
  term_t       z3_r;
  acc_t        sum3_r;
  logic [7:0]  v3_lo_r;
  logic [63:0] pb_hh_r, pb_hl_r, pb_lh_r, pb_ll_r;
  logic [63:0] pb_hh_nxt, pb_hl_nxt, pb_lh_nxt, pb_ll_nxt;

  assign pb_hh_nxt = 64'(v2_r[61:32]) * 64'(RECIP_HI);
  assign pb_hl_nxt = 64'(v2_r[61:32]) * 64'(RECIP_LO);
  assign pb_lh_nxt = 64'(v2_r[31:0]) * 64'(RECIP_HI);
  assign pb_ll_nxt = 64'(v2_r[31:0]) * 64'(RECIP_LO);

  // Stage 4: quotient estimate
  asf_side_t    side4_r;
  term_t        z4_r;
  acc_t         sum4_r;
  logic [7:0]   v4_lo_r;
  term_t        q4_r;
  logic [127:0] prod_b;

  assign prod_b = (128'(pb_hh_r) << 64) + ((128'(pb_hl_r) + 128'(pb_lh_r)) << 32)
                + 128'(pb_ll_r);

  // Stage 5: correct the estimate; the remainder is below 2k, so its low byte
  // is the whole remainder
  asf_side_t  side5_r;
  term_t      z5_r;
  acc_t       sum5_r;
  term_t      term5_r;
  logic [7:0] qk_lo;
  logic [7:0] rem_lo;
  term_t      term5_nxt;

  assign qk_lo     = q4_r[7:0] * DIV_LO;
  assign rem_lo    = v4_lo_r - qk_lo;
  assign term5_nxt = (rem_lo >= DIV_LO) ? q4_r + TERM_BITS'(1) : q4_r;

  // Advance side-band control; reset clears only the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.vld <= 1'b0;
      side2_r.vld <= 1'b0;
      side3_r.vld <= 1'b0;
      side4_r.vld <= 1'b0;
      side5_r.vld <= 1'b0;
    end else if (en) begin
      side1_r <= side_in;
      side2_r <= side1_r;
      side3_r <= side2_r;
      side4_r <= side3_r;
      side5_r <= side4_r;
    end
  end

  // Advance datapath
  always_ff @(posedge clk) begin
    if (en) begin
      z1_r    <= z_in;
      sum1_r  <= sum1_nxt;
      pa_hh_r <= pa_hh_nxt;
      pa_hl_r <= pa_hl_nxt;
      pa_lh_r <= pa_lh_nxt;
      pa_ll_r <= pa_ll_nxt;

      z2_r   <= z1_r;
      sum2_r <= sum1_r;
      v2_r   <= prod_a[123:62];

      z3_r    <= z2_r;
      sum3_r  <= sum2_r;
      v3_lo_r <= v2_r[7:0];
      pb_hh_r <= pb_hh_nxt;
      pb_hl_r <= pb_hl_nxt;
      pb_lh_r <= pb_lh_nxt;
      pb_ll_r <= pb_ll_nxt;

      z4_r    <= z3_r;
      sum4_r  <= sum3_r;
      v4_lo_r <= v3_lo_r;
      q4_r    <= prod_b[125:64];

      z5_r    <= z4_r;
      sum5_r  <= sum4_r;
      term5_r <= term5_nxt;
    end
  end

  assign side_out = side5_r;
  assign z_out    = z5_r;
  assign term_out = term5_r;
  assign sum_out  = sum5_r;

endmodule

`default_nettype wire

[rtl/core/anisotropic_scale_factor.sv]
// Anisotropic scale factor exp(-Q/4) as mantissa and base-2 exponent; uses asf_pkg, asf_exp_step.
// Stages: nine front stages (quadratic form, clamp, base-2 split, ln 2 scaling), sixteen series
// terms of five stages each, then the output slot.
// Throughput: one item per cycle; the pipeline halts only when both output slots are full.
// Reset: synchronous, active low; clears the valid bits of all stages and both output slots, and the coefficients.
`default_nettype none

module anisotropic_scale_factor #(
  parameter int unsigned INDEX_BITS    = 9,
  parameter int unsigned MANTISSA_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [INDEX_BITS-1:0]          in_index_h,
  input  logic signed [INDEX_BITS-1:0]          in_index_k,
  input  logic signed [INDEX_BITS-1:0]          in_index_l,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [MANTISSA_BITS-1:0]              out_mantissa,
  output logic signed [asf_pkg::EXP_BITS-1:0]   out_exponent,
  output logic                                  out_clamped,
  output logic                                  out_underflow,
  input  logic                                  cfg_wr_en,
  input  logic [asf_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [asf_pkg::COEF_BITS-1:0]         cfg_data
);
  import asf_pkg::*;

  localparam int unsigned SQ_W   = 2 * INDEX_BITS;
  localparam int unsigned CR_W   = SQ_W + 1;
  localparam int unsigned PROD_W = COEF_BITS + CR_W;
  localparam int unsigned Q_W    = PROD_W + 3;

  localparam logic signed [Q_W-1:0]     Q_CLAMP = -(Q_W'(160) <<< 32);
  localparam logic signed [Q_W-1:0]     Q_FLUSH = Q_W'(1) <<< 41;
  localparam logic signed [XP_BITS-1:0] L_HI    = XP_BITS'(LOG2E_Q63[63:32]);
  localparam logic signed [XP_BITS-1:0] L_LO    = XP_BITS'(LOG2E_Q63[31:0]);
  localparam logic signed [N_BITS-1:0]  N_MIN   = N_BITS'(-126);

  typedef struct packed {
    logic [MANTISSA_BITS-1:0]   mantissa;
    logic signed [EXP_BITS-1:0] exponent;
    logic                       clamped;
    logic                       underflow;
  } res_t;

  logic en;

  // Coefficient registers
  logic signed [COEF_BITS-1:0] coef_hh_r, coef_kk_r, coef_ll_r;
  logic signed [COEF_BITS-1:0] coef_hk_r, coef_hl_r, coef_kl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_hh_r <= '0;
      coef_kk_r <= '0;
      coef_ll_r <= '0;
      coef_hk_r <= '0;
      coef_hl_r <= '0;
      coef_kl_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HH:  coef_hh_r <= cfg_data;
        CFG_KK:  coef_kk_r <= cfg_data;
        CFG_LL:  coef_ll_r <= cfg_data;
        CFG_HK:  coef_hk_r <= cfg_data;
        CFG_HL:  coef_hl_r <= cfg_data;
        CFG_KL:  coef_kl_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: index squares and doubled cross products
  logic                   vld_s1_r;
  logic signed [SQ_W-1:0] sq_hh_s1_r, sq_kk_s1_r, sq_ll_s1_r;
  logic signed [CR_W-1:0] cr_hk_s1_r, cr_hl_s1_r, cr_kl_s1_r;
  logic signed [SQ_W-1:0] sq_hh_nxt, sq_kk_nxt, sq_ll_nxt;
  logic signed [CR_W-1:0] cr_hk_nxt, cr_hl_nxt, cr_kl_nxt;

  assign sq_hh_nxt = SQ_W'(in_index_h) * SQ_W'(in_index_h);
  assign sq_kk_nxt = SQ_W'(in_index_k) * SQ_W'(in_index_k);
  assign sq_ll_nxt = SQ_W'(in_index_l) * SQ_W'(in_index_l);
  assign cr_hk_nxt = (CR_W'(in_index_h) * CR_W'(in_index_k)) <<< 1;
  assign cr_hl_nxt = (CR_W'(in_index_h) * CR_W'(in_index_l)) <<< 1;
  assign cr_kl_nxt = (CR_W'(in_index_k) * CR_W'(in_index_l)) <<< 1;

  // Stage 2: coefficient products
  logic                     vld_s2_r;
  logic signed [PROD_W-1:0] t_hh_s2_r, t_kk_s2_r, t_ll_s2_r;
  logic signed [PROD_W-1:0] t_hk_s2_r, t_hl_s2_r, t_kl_s2_r;
  logic signed [PROD_W-1:0] t_hh_nxt, t_kk_nxt, t_ll_nxt, t_hk_nxt, t_hl_nxt, t_kl_nxt;

  assign t_hh_nxt = PROD_W'(coef_hh_r) * PROD_W'(sq_hh_s1_r);
  assign t_kk_nxt = PROD_W'(coef_kk_r) * PROD_W'(sq_kk_s1_r);
  assign t_ll_nxt = PROD_W'(coef_ll_r) * PROD_W'(sq_ll_s1_r);
  assign t_hk_nxt = PROD_W'(coef_hk_r) * PROD_W'(cr_hk_s1_r);
  assign t_hl_nxt = PROD_W'(coef_hl_r) * PROD_W'(cr_hl_s1_r);
  assign t_kl_nxt = PROD_W'(coef_kl_r) * PROD_W'(cr_kl_s1_r);

  // Stage 3: pairwise sums
  logic                  vld_s3_r;
  logic signed [Q_W-1:0] c0_s3_r, c1_s3_r, c2_s3_r;
  logic signed [Q_W-1:0] c0_nxt, c1_nxt, c2_nxt;

  assign c0_nxt = Q_W'(t_hh_s2_r) + Q_W'(t_kk_s2_r);
  assign c1_nxt = Q_W'(t_ll_s2_r) + Q_W'(t_hk_s2_r);
  assign c2_nxt = Q_W'(t_hl_s2_r) + Q_W'(t_kl_s2_r);

  // Stage 4: exact quadratic form
  logic                  vld_s4_r;
  logic signed [Q_W-1:0] q_s4_r;
  logic signed [Q_W-1:0] q_nxt;

  assign q_nxt = c0_s3_r + c1_s3_r + c2_s3_r;

  // Stage 5: clamp at 40, flag flush below -128, negate into x
  logic                     vld_s5_r;
  logic signed [X_BITS-1:0] x_s5_r;
  logic                     clamp_s5_r, flush_s5_r;
  logic                     clamp_nxt, flush_nxt;
  logic signed [X_BITS-1:0] x_nxt;

  assign clamp_nxt = (q_s4_r < Q_CLAMP);
  assign flush_nxt = (q_s4_r > Q_FLUSH);
  assign x_nxt     = clamp_nxt ? X_CLAMP : X_BITS'(-q_s4_r);

  // Stage 6: upper and lower parts of x times the two halves of log2(e)
  logic                       vld_s6_r;
  logic signed [XP_BITS-1:0]  xp_hh_s6_r, xp_hl_s6_r, xp_lh_s6_r, xp_ll_s6_r;
  logic                       clamp_s6_r, flush_s6_r;
  logic signed [XHI_BITS-1:0] x_hi;
  logic signed [XLO_BITS:0]   x_lo;
  logic signed [XP_BITS-1:0]  xp_hh_nxt, xp_hl_nxt, xp_lh_nxt, xp_ll_nxt;

  assign x_hi      = x_s5_r[X_BITS-1:XLO_BITS];
  assign x_lo      = {1'b0, x_s5_r[XLO_BITS-1:0]};
  assign xp_hh_nxt = XP_BITS'(x_hi) * L_HI;
  assign xp_hl_nxt = XP_BITS'(x_hi) * L_LO;
  assign xp_lh_nxt = XP_BITS'(x_lo) * L_HI;
  assign xp_ll_nxt = XP_BITS'(x_lo) * L_LO;

  // Stage 7: split the base-2 argument into integer n and fraction f
  logic                     vld_s7_r;
  logic [63:0]              f_s7_r;
  logic signed [N_BITS-1:0] n_s7_r;
  logic                     clamp_s7_r, flush_s7_r;
  logic signed [Y_BITS-1:0] y_full;

  assign y_full = (Y_BITS'(xp_hh_s6_r) <<< (32 + XLO_BITS)) + (Y_BITS'(xp_hl_s6_r) <<< XLO_BITS)
                + (Y_BITS'(xp_lh_s6_r) <<< 32) + Y_BITS'(xp_ll_s6_r);

  // Stage 8: fraction times ln 2, partial products
  asf_side_t   side_s8_r;
  logic [63:0] pz_hh_s8_r, pz_hl_s8_r, pz_lh_s8_r, pz_ll_s8_r;
  asf_side_t   side_s8_nxt;
  logic [63:0] pz_hh_nxt, pz_hl_nxt, pz_lh_nxt, pz_ll_nxt;

  assign pz_hh_nxt = 64'(f_s7_r[63:32]) * 64'(LN2_Q64[63:32]);
  assign pz_hl_nxt = 64'(f_s7_r[63:32]) * 64'(LN2_Q64[31:0]);
  assign pz_lh_nxt = 64'(f_s7_r[31:0]) * 64'(LN2_Q64[63:32]);
  assign pz_ll_nxt = 64'(f_s7_r[31:0]) * 64'(LN2_Q64[31:0]);

  always_comb begin
    side_s8_nxt.vld       = vld_s7_r;
    side_s8_nxt.clamped   = clamp_s7_r;
    side_s8_nxt.underflow = flush_s7_r | (n_s7_r < N_MIN);
    side_s8_nxt.exponent  = EXP_BITS'(n_s7_r);
  end

  // Stage 9: z = series argument with 62 fraction bits
  asf_side_t    side_s9_r;
  term_t        z_s9_r;
  logic [127:0] z_full;

  assign z_full = (128'(pz_hh_s8_r) << 64) + ((128'(pz_hl_s8_r) + 128'(pz_lh_s8_r)) << 32)
                + 128'(pz_ll_s8_r);

  // Front valid bits and side-band control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r      <= 1'b0;
      vld_s2_r      <= 1'b0;
      vld_s3_r      <= 1'b0;
      vld_s4_r      <= 1'b0;
      vld_s5_r      <= 1'b0;
      vld_s6_r      <= 1'b0;
      vld_s7_r      <= 1'b0;
      side_s8_r.vld <= 1'b0;
      side_s9_r.vld <= 1'b0;
    end else if (en) begin
      vld_s1_r  <= in_valid;
      vld_s2_r  <= vld_s1_r;
      vld_s3_r  <= vld_s2_r;
      vld_s4_r  <= vld_s3_r;
      vld_s5_r  <= vld_s4_r;
      vld_s6_r  <= vld_s5_r;
      vld_s7_r  <= vld_s6_r;
      side_s8_r <= side_s8_nxt;
      side_s9_r <= side_s8_r;
    end
  end

  // Front datapath
  always_ff @(posedge clk) begin
    if (en) begin
      sq_hh_s1_r <= sq_hh_nxt;
      sq_kk_s1_r <= sq_kk_nxt;
      sq_ll_s1_r <= sq_ll_nxt;
      cr_hk_s1_r <= cr_hk_nxt;
      cr_hl_s1_r <= cr_hl_nxt;
      cr_kl_s1_r <= cr_kl_nxt;

      t_hh_s2_r <= t_hh_nxt;
      t_kk_s2_r <= t_kk_nxt;
      t_ll_s2_r <= t_ll_nxt;
      t_hk_s2_r <= t_hk_nxt;
      t_hl_s2_r <= t_hl_nxt;
      t_kl_s2_r <= t_kl_nxt;

      c0_s3_r <= c0_nxt;
      c1_s3_r <= c1_nxt;
      c2_s3_r <= c2_nxt;

      q_s4_r <= q_nxt;

      x_s5_r     <= x_nxt;
      clamp_s5_r <= clamp_nxt;
      flush_s5_r <= flush_nxt;

      xp_hh_s6_r <= xp_hh_nxt;
      xp_hl_s6_r <= xp_hl_nxt;
      xp_lh_s6_r <= xp_lh_nxt;
      xp_ll_s6_r <= xp_ll_nxt;
      clamp_s6_r <= clamp_s5_r;
      flush_s6_r <= flush_s5_r;

      f_s7_r     <= y_full[96:33];
      n_s7_r     <= y_full[Y_BITS-1:97];
      clamp_s7_r <= clamp_s6_r;
      flush_s7_r <= flush_s6_r;

      pz_hh_s8_r <= pz_hh_nxt;
      pz_hl_s8_r <= pz_hl_nxt;
      pz_lh_s8_r <= pz_lh_nxt;
      pz_ll_s8_r <= pz_ll_nxt;

      z_s9_r <= z_full[127:66];
    end
  end

  // Series chain: first term is z itself, steps add terms one to sixteen and
  // produce terms two to seventeen
  asf_side_t chain_side [NUM_STEPS+1];
  term_t     chain_z    [NUM_STEPS+1];
  term_t     chain_term [NUM_STEPS+1];
  acc_t      chain_sum  [NUM_STEPS+1];

  assign chain_side[0] = side_s9_r;
  assign chain_z[0]    = z_s9_r;
  assign chain_term[0] = z_s9_r;
  assign chain_sum[0]  = ACC_ONE;

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
    asf_exp_step #(
      .DIVISOR (g + 2)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .side_in  (chain_side[g]),
      .z_in     (chain_z[g]),
      .term_in  (chain_term[g]),
      .sum_in   (chain_sum[g]),
      .side_out (chain_side[g+1]),
      .z_out    (chain_z[g+1]),
      .term_out (chain_term[g+1]),
      .sum_out  (chain_sum[g+1])
    );
  end

  // Final term, truncate to the mantissa, flush on underflow
  acc_t      sum_fin;
  asf_side_t side_fin;
  res_t      push_res;
  logic      push;

  assign side_fin = chain_side[NUM_STEPS];
  assign sum_fin  = chain_sum[NUM_STEPS] + ACC_BITS'(chain_term[NUM_STEPS]);
  assign push     = en & side_fin.vld;

  always_comb begin
    push_res.clamped   = side_fin.clamped;
    push_res.underflow = side_fin.underflow;
    if (side_fin.underflow) begin
      push_res.mantissa = '0;
      push_res.exponent = '0;
    end else begin
      push_res.mantissa = sum_fin[ACC_BITS-1 -: MANTISSA_BITS];
      push_res.exponent = side_fin.exponent;
    end
  end

  // Output slot plus skid slot; the pipeline holds only while the skid is full
  logic out_vld_r, skid_vld_r;
  res_t out_res_r, skid_res_r;
  logic out_vld_nxt, skid_vld_nxt;
  res_t out_res_nxt, skid_res_nxt;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_res_nxt  = out_res_r;
    skid_res_nxt = skid_res_r;
    if (skid_vld_r) begin
      if (out_ready) begin
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (out_vld_r && !out_ready) begin
      if (push) begin
        skid_res_nxt = push_res;
        skid_vld_nxt = 1'b1;
      end
    end else begin
      out_vld_nxt = push;
      out_res_nxt = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign en            = ~skid_vld_r;
  assign in_ready      = en;
  assign out_valid     = out_vld_r;
  assign out_mantissa  = out_res_r.mantissa;
  assign out_exponent  = out_res_r.exponent;
  assign out_clamped   = out_res_r.clamped;
  assign out_underflow = out_res_r.underflow;

endmodule

`default_nettype wire

[verif/anisotropic_scale_factor_tb.sv]
// Self-checking testbench for anisotropic_scale_factor: streams Miller index triples under
// several tensor settings and checks each exp(-Q/4) result against an in-bench predictor.
// Depends on asf_pkg and the anisotropic_scale_factor RTL only.

module anisotropic_scale_factor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asf_pkg::*;

  localparam int unsigned INDEX_BITS    = 9;
  localparam int unsigned MANTISSA_BITS = 24;
  localparam int unsigned RESET_CYCLES  = 5;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS   = 56;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS   = 40;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_B = 3'd7;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE = 40'sh01_0000_0000;
  localparam logic signed [COEF_BITS-1:0] COEF_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = 40'sh80_0000_0000;

  // Fixed-point constants of the exponential path
  localparam logic signed [127:0] ARG_LIMIT_Q  = 128'sd160 <<< 32;
  localparam logic signed [127:0] FLUSH_FORM_Q = 128'sd1 <<< 41;
  localparam logic [63:0]         LOG2E_Q63    = 64'hB8AA_3B29_5C17_F0BC;
  localparam logic [63:0]         LN2_Q64      = 64'hB172_17F7_D1CF_79AB;
  localparam logic [63:0]         ONE_Q62      = 64'h4000_0000_0000_0000;
  localparam int                  MIN_EXPONENT = -126;
  localparam int unsigned         SERIES_TERMS = 24;

  typedef struct packed {
    logic [MANTISSA_BITS-1:0]   mantissa;
    logic signed [EXP_BITS-1:0] exponent;
    logic                       clamped;
    logic                       underflow;
  } factor_t;

  // Holds the tensor copy and the queue of scale factors still owed by the block
  class scale_factor_board;
    logic signed [COEF_BITS-1:0] tensor [6];
    factor_t                     expected_factors [$];
    int unsigned                 errors;

    function new();
      foreach (tensor[i]) tensor[i] = '0;
      errors = 0;
    endfunction

    function void set_coef(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
      if (idx <= CFG_KL) tensor[idx] = data;
    endfunction

    function int unsigned pending();
      return expected_factors.size();
    endfunction

    function factor_t scale_factor_of(logic signed [INDEX_BITS-1:0] h,
                                      logic signed [INDEX_BITS-1:0] k,
                                      logic signed [INDEX_BITS-1:0] l);
      logic signed [127:0] hw, kw, lw, q, x;
      logic signed [127:0] c [6];
      logic signed [191:0] y;
      logic [127:0]        prod;
      logic [63:0]         frac, z, term, sum;
      int                  n, i;
      factor_t             r;
      r = '0;
      hw = h;
      kw = k;
      lw = l;
      foreach (c[j]) c[j] = tensor[j];
      // exact quadratic form, 32 fraction bits
      q = c[CFG_HH] * hw * hw + c[CFG_KK] * kw * kw + c[CFG_LL] * lw * lw
        + 2 * (c[CFG_HK] * hw * kw + c[CFG_HL] * hw * lw + c[CFG_KL] * kw * lw);
      // argument below -128: flush at once
      if (q > FLUSH_FORM_Q) begin
        r.underflow = 1'b1;
        return r;
      end
      // argument above 40: limit it
      if (q < -ARG_LIMIT_Q) begin
        r.clamped = 1'b1;
        x = ARG_LIMIT_Q;
      end else begin
        x = -q;
      end
      // base-2 split: integer exponent and 64-bit fraction
      y = x * $signed({1'b0, LOG2E_Q63});
      frac = y[96:33];
      n = int'(y >>> 97);
      if (n < MIN_EXPONENT) begin
        r.underflow = 1'b1;
        return r;
      end
      // back to natural base, 62 fraction bits, then the Taylor series
      prod = frac * LN2_Q64;
      z = prod[127:66];
      term = ONE_Q62;
      sum = term;
      for (i = 1; i <= SERIES_TERMS; i++) begin
        prod = term * z;
        term = 64'(prod >> 62) / 64'(i);
        sum += term;
      end
      r.mantissa = sum[62 -: MANTISSA_BITS];
      r.exponent = EXP_BITS'(n);
      return r;
    endfunction

    function void note_input(logic signed [INDEX_BITS-1:0] h,
                             logic signed [INDEX_BITS-1:0] k,
                             logic signed [INDEX_BITS-1:0] l);
      expected_factors.push_back(scale_factor_of(h, k, l));
    endfunction

    function void check_result(factor_t got);
      factor_t want;
      if (expected_factors.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: mant %h exp %0d clamp %b uflow %b",
                   $time, got.mantissa, got.exponent, got.clamped, got.underflow);
        return;
      end
      want = expected_factors.pop_front();
      if (got.mantissa !== want.mantissa || got.exponent !== want.exponent ||
          got.clamped !== want.clamped || got.underflow !== want.underflow) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: expected mant %h exp %0d clamp %b uflow %b, actual mant %h exp %0d clamp %b uflow %b",
                   $time, want.mantissa, want.exponent, want.clamped, want.underflow,
                   got.mantissa, got.exponent, got.clamped, got.underflow);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n         = 1'b0;
  logic                           in_valid      = 1'b0;
  logic                           in_ready;
  logic signed [INDEX_BITS-1:0]   in_index_h    = '0;
  logic signed [INDEX_BITS-1:0]   in_index_k    = '0;
  logic signed [INDEX_BITS-1:0]   in_index_l    = '0;
  logic                           out_valid;
  logic                           out_ready     = 1'b0;
  logic [MANTISSA_BITS-1:0]       out_mantissa;
  logic signed [EXP_BITS-1:0]     out_exponent;
  logic                           out_clamped;
  logic                           out_underflow;
  logic                           cfg_wr_en     = 1'b0;
  logic [CFG_IDX_BITS-1:0]        cfg_index     = '0;
  logic [COEF_BITS-1:0]           cfg_data      = '0;

  scale_factor_board board;
  bit                calm = 1'b0;
  int unsigned       rx_hold = 0;

  anisotropic_scale_factor #(
    .INDEX_BITS   (INDEX_BITS),
    .MANTISSA_BITS(MANTISSA_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_index_h   (in_index_h),
    .in_index_k   (in_index_k),
    .in_index_l   (in_index_l),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_mantissa (out_mantissa),
    .out_exponent (out_exponent),
    .out_clamped  (out_clamped),
    .out_underflow(out_underflow),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long; none at all in calm phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Mostly small indices so the form lands in range; sometimes full width or zero
  function automatic logic signed [INDEX_BITS-1:0] rand_index();
    int unsigned w;
    int          v;
    case ($urandom_range(0, 7))
      0: return INDEX_BITS'($urandom);
      1: return '0;
      default: begin
        w = $urandom_range(1, 6);
        v = int'($urandom_range(0, (1 << w) - 1));
        if ($urandom_range(0, 1) != 0) v = -v;
        return INDEX_BITS'(v);
      end
    endcase
  endfunction

  // Scaled coefficients keep most arguments between the flush and clamp limits
  function automatic logic signed [COEF_BITS-1:0] rand_coef(bit diag);
    logic signed [COEF_BITS-1:0] v;
    v = COEF_BITS'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: v = '0;
      1: ;
      default: begin
        v = v >>> $urandom_range(6, 17);
        if (diag && v < 0 && $urandom_range(0, 3) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic send_index(input logic signed [INDEX_BITS-1:0] h,
                            input logic signed [INDEX_BITS-1:0] k,
                            input logic signed [INDEX_BITS-1:0] l);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_index_h <= h;
    in_index_k <= k;
    in_index_l <= l;
    // hold until the transfer
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_hkl(input int h, input int k, input int l);
    send_index(INDEX_BITS'(h), INDEX_BITS'(k), INDEX_BITS'(l));
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [COEF_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_coef(idx, data);
  endtask

  task automatic set_tensor(input logic signed [COEF_BITS-1:0] hh, kk, ll, hk, hl, kl);
    wait_drained();
    write_coef(CFG_HH, hh);
    write_coef(CFG_KK, kk);
    write_coef(CFG_LL, ll);
    write_coef(CFG_HK, hk);
    write_coef(CFG_HL, hl);
    write_coef(CFG_KL, kl);
    cfg_wr_en <= 1'b0;
  endtask

  // Record transfers on both channels and drive the receiver's stalls
  always @(posedge clk) begin
    factor_t     got;
    int unsigned g;
    if (rst_n && in_valid && in_ready)
      board.note_input(in_index_h, in_index_k, in_index_l);
    if (rst_n && out_valid && out_ready) begin
      got.mantissa  = out_mantissa;
      got.exponent  = out_exponent;
      got.clamped   = out_clamped;
      got.underflow = out_underflow;
      board.check_result(got);
    end
    if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      g = pick_gap();
      if (g == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_hold = g - 1;
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic signed [COEF_BITS-1:0] coefs [6];
    int unsigned                 p, i, idx;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unmapped indexes must leave the tensor alone
    write_coef(CFG_UNUSED_A, COEF_MAX);
    write_coef(CFG_UNUSED_B, COEF_MIN);
    cfg_wr_en <= 1'b0;

    // zero tensor after reset: every triple gives exactly one
    send_hkl(0, 0, 0);
    send_hkl(-256, 255, -256);
    send_hkl(255, -256, 255);

    // diagonal tensor: plain values, both underflow paths, the clamp and its boundary
    set_tensor(COEF_ONE, -(40'sd40 <<< 32), 40'sd1 <<< 25, '0, '0, '0);
    send_hkl(0, 0, 0);
    send_hkl(1, 0, 0);
    send_hkl(2, 0, 0);
    send_hkl(-2, 0, 0);
    send_hkl(12, 0, 0);
    send_hkl(18, 0, 55);
    send_hkl(19, 0, 0);
    send_hkl(22, 0, 0);
    send_hkl(23, 0, 0);
    send_hkl(0, 2, 0);
    send_hkl(0, -2, 0);
    send_hkl(0, 3, 0);
    send_hkl(0, -256, 0);
    send_hkl(0, 0, -256);
    send_hkl(0, 0, 255);
    send_hkl(1, 1, 0);

    // cross terms only
    set_tensor('0, '0, '0, 40'sh00_8000_0000, -40'sh00_8000_0000, 40'sh00_C000_0000);
    send_hkl(1, 1, 1);
    send_hkl(2, -3, 1);
    send_hkl(-1, 4, 2);

    // coefficient extremes
    set_tensor(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    send_hkl(0, 0, 0);
    send_hkl(1, 0, 0);
    send_hkl(0, 1, 0);
    send_hkl(255, -256, 255);

    // random tensors, each with a full drain halfway through
    for (p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      calm = ($urandom_range(0, 3) == 0);
      for (idx = 0; idx < 6; idx++) coefs[idx] = rand_coef(idx <= CFG_LL);
      set_tensor(coefs[0], coefs[1], coefs[2], coefs[3], coefs[4], coefs[5]);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) wait_drained();
        send_index(rand_index(), rand_index(), rand_index());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      $display("%0t: %0d results never arrived", $time, board.pending());
    if (board.errors == 0 && board.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/asf_pkg.sv
rtl/core/asf_exp_step.sv
rtl/core/anisotropic_scale_factor.sv
verif/anisotropic_scale_factor_tb.sv
